// File: hw/rtl/spoq_pkg.sv
// Shared constants, codes and types of the stable priority order queue.
`timescale 1ns / 1ps
`default_nettype none
package spoq_pkg;

    localparam int DEPTH  = 16;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int PRI_W  = 8;
    localparam int TAG_W  = 16;
    localparam int OP_W   = 2;
    localparam int STAT_W = 2;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_FINISH = 2'd1;
    localparam logic [OP_W-1:0] OP_MOVE   = 2'd2;
    localparam logic [OP_W-1:0] OP_READ   = 2'd3;

    localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL      = 2'd1;
    localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd2;
    localparam logic [STAT_W-1:0] STAT_BAD_POS   = 2'd3;

    // Broadcast to every cell: shift window [lo, hi] and an optional write at put_pos.
    typedef struct packed {
        logic             shift_en;
        logic             take_right;
        logic [IDX_W-1:0] lo;
        logic [IDX_W-1:0] hi;
        logic             put_en;
        logic [IDX_W-1:0] put_pos;
        logic [PRI_W-1:0] put_pri;
        logic [TAG_W-1:0] put_tag;
    } t_cell_ctrl;

endpackage
`default_nettype wire

// File: hw/rtl/spoq_cell.sv
// One list slot: holds an entry, compares it with the request, shifts to or from neighbors.
`timescale 1ns / 1ps
`default_nettype none
module spoq_cell import spoq_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic [IDX_W-1:0] i_index,
    input  wire logic             i_apply,
    input  wire t_cell_ctrl       i_ctrl,
    input  wire logic [PRI_W-1:0] i_left_pri,
    input  wire logic [TAG_W-1:0] i_left_tag,
    input  wire logic [PRI_W-1:0] i_right_pri,
    input  wire logic [TAG_W-1:0] i_right_tag,
    input  wire logic [PRI_W-1:0] i_req_pri,
    input  wire logic [TAG_W-1:0] i_req_tag,
    output logic      [PRI_W-1:0] o_pri,
    output logic      [TAG_W-1:0] o_tag,
    output logic                  o_ge,
    output logic                  o_match
);

    logic [PRI_W-1:0] r_pri;
    logic [TAG_W-1:0] r_tag;
    logic [PRI_W-1:0] n_pri;
    logic [TAG_W-1:0] n_tag;
    logic             w_in_win;

    assign w_in_win = (i_index >= i_ctrl.lo) && (i_index <= i_ctrl.hi);

    always_comb begin
        n_pri = r_pri;
        n_tag = r_tag;
        if (i_ctrl.put_en && (i_index == i_ctrl.put_pos)) begin
            n_pri = i_ctrl.put_pri;
            n_tag = i_ctrl.put_tag;
        end else if (i_ctrl.shift_en && w_in_win) begin
            if (i_ctrl.take_right) begin
                n_pri = i_right_pri;
                n_tag = i_right_tag;
            end else begin
                n_pri = i_left_pri;
                n_tag = i_left_tag;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_apply) begin
            r_pri <= n_pri;
            r_tag <= n_tag;
        end
    end

    assign o_pri   = r_pri;
    assign o_tag   = r_tag;
    assign o_ge    = (r_pri >= i_req_pri);
    assign o_match = (r_tag == i_req_tag);

endmodule
`default_nettype wire

// File: hw/rtl/stable_priority_order_queue_core.sv
// Top level: chain of list cells and the three-step command sequencer.
//
//  channel   signals                                          direction
//  command   start, i_opcode, i_priority_req, i_tag,          in
//            i_from_pos, i_to_pos (busy is out)
//  result    o_valid, o_status, o_count, o_position,          out
//            o_entry_priority, o_entry_tag
//
// Each item is handled in steps: compare in every cell at accept, resolve position
// and status from the registered flags, then shift the cell chain.
// The result strobe o_valid is high in the shift cycle; busy falls with it.
// Reset clears the entry count and the sequencer; cell contents stay as they are.
// The receiver cannot stall; results are never held back.
`timescale 1ns / 1ps
`default_nettype none
module stable_priority_order_queue_core import spoq_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic [OP_W-1:0]   i_opcode,
    input  wire logic [PRI_W-1:0]  i_priority_req,
    input  wire logic [TAG_W-1:0]  i_tag,
    input  wire logic [IDX_W-1:0]  i_from_pos,
    input  wire logic [IDX_W-1:0]  i_to_pos,
    output logic                   o_valid,
    output logic      [STAT_W-1:0] o_status,
    output logic      [CNT_W-1:0]  o_count,
    output logic      [IDX_W-1:0]  o_position,
    output logic      [PRI_W-1:0]  o_entry_priority,
    output logic      [TAG_W-1:0]  o_entry_tag
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_APPLY
    } t_state;

    t_state             r_state;
    logic [OP_W-1:0]    r_op;
    logic [PRI_W-1:0]   r_pri;
    logic [TAG_W-1:0]   r_tag;
    logic [IDX_W-1:0]   r_from;
    logic [IDX_W-1:0]   r_to;
    logic [DEPTH-1:0]   r_ge;
    logic [DEPTH-1:0]   r_match;
    logic [CNT_W-1:0]   r_count;
    t_cell_ctrl         r_ctrl;
    logic               r_valid;
    logic [STAT_W-1:0]  r_status;
    logic [IDX_W-1:0]   r_position;
    logic [PRI_W-1:0]   r_entry_pri;
    logic [TAG_W-1:0]   r_entry_tag;

    t_cell_ctrl         n_ctrl;
    logic [CNT_W-1:0]   n_count;
    logic [STAT_W-1:0]  n_status;
    logic [IDX_W-1:0]   n_position;
    logic [PRI_W-1:0]   n_entry_pri;
    logic [TAG_W-1:0]   n_entry_tag;

    logic [PRI_W-1:0]   w_pri   [DEPTH];
    logic [TAG_W-1:0]   w_tag   [DEPTH];
    logic [DEPTH-1:0]   w_ge;
    logic [DEPTH-1:0]   w_match;
    logic [DEPTH-1:0]   w_live;
    logic               w_accept;
    logic               w_apply;
    logic [CNT_W-1:0]   w_ins_cnt;
    logic [IDX_W-1:0]   w_hit_pos;
    logic               w_found;
    logic               w_from_ok;
    logic               w_to_ok;
    logic [PRI_W-1:0]   w_sel_pri;
    logic [TAG_W-1:0]   w_sel_tag;

    assign w_accept = start && (r_state == ST_IDLE);
    assign w_apply  = (r_state == ST_APPLY);
    assign busy     = (r_state != ST_IDLE);

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            logic [PRI_W-1:0] w_lp;
            logic [TAG_W-1:0] w_lt;
            logic [PRI_W-1:0] w_rp;
            logic [TAG_W-1:0] w_rt;
            if (g == 0) begin : g_first
                assign w_lp = '0;
                assign w_lt = '0;
            end else begin : g_mid_l
                assign w_lp = w_pri[g-1];
                assign w_lt = w_tag[g-1];
            end
            if (g == DEPTH - 1) begin : g_last
                assign w_rp = '0;
                assign w_rt = '0;
            end else begin : g_mid_r
                assign w_rp = w_pri[g+1];
                assign w_rt = w_tag[g+1];
            end
            spoq_cell u_cell (
                .i_clk       (i_clk),
                .i_index     (IDX_W'(g)),
                .i_apply     (w_apply),
                .i_ctrl      (r_ctrl),
                .i_left_pri  (w_lp),
                .i_left_tag  (w_lt),
                .i_right_pri (w_rp),
                .i_right_tag (w_rt),
                .i_req_pri   (i_priority_req),
                .i_req_tag   (i_tag),
                .o_pri       (w_pri[g]),
                .o_tag       (w_tag[g]),
                .o_ge        (w_ge[g]),
                .o_match     (w_match[g])
            );
            assign w_live[g] = (CNT_W'(g) < r_count);
        end
    endgenerate

    // position resolve from registered flags
    always_comb begin
        w_ins_cnt = '0;
        w_hit_pos = '0;
        for (int i = 0; i < DEPTH; i++) begin
            w_ins_cnt = w_ins_cnt + CNT_W'(r_ge[i]);
        end
        for (int i = DEPTH - 1; i >= 0; i--) begin
            if (r_match[i]) begin
                w_hit_pos = IDX_W'(i);
            end
        end
    end

    assign w_found   = |r_match;
    assign w_from_ok = ({1'b0, r_from} < r_count);
    assign w_to_ok   = ({1'b0, r_to} < r_count);
    assign w_sel_pri = w_pri[r_from];
    assign w_sel_tag = w_tag[r_from];

    always_comb begin
        n_ctrl      = '0;
        n_count     = r_count;
        n_status    = STAT_OK;
        n_position  = '0;
        n_entry_pri = '0;
        n_entry_tag = '0;
        case (r_op)
            OP_INSERT: begin
                if (r_count == CNT_W'(DEPTH)) begin
                    n_status = STAT_FULL;
                end else begin
                    n_position       = w_ins_cnt[IDX_W-1:0];
                    n_ctrl.shift_en  = 1'b1;
                    n_ctrl.lo        = w_ins_cnt[IDX_W-1:0];
                    n_ctrl.hi        = IDX_W'(DEPTH - 1);
                    n_ctrl.put_en    = 1'b1;
                    n_ctrl.put_pos   = w_ins_cnt[IDX_W-1:0];
                    n_ctrl.put_pri   = r_pri;
                    n_ctrl.put_tag   = r_tag;
                    n_count          = r_count + CNT_W'(1);
                end
            end
            OP_FINISH: begin
                if (!w_found) begin
                    n_status = STAT_NOT_FOUND;
                end else begin
                    n_position        = w_hit_pos;
                    n_ctrl.shift_en   = 1'b1;
                    n_ctrl.take_right = 1'b1;
                    n_ctrl.lo         = w_hit_pos;
                    n_ctrl.hi         = IDX_W'(DEPTH - 1);
                    n_count           = r_count - CNT_W'(1);
                end
            end
            OP_MOVE: begin
                if (!w_from_ok || !w_to_ok) begin
                    n_status = STAT_BAD_POS;
                end else begin
                    n_position        = r_to;
                    n_ctrl.shift_en   = 1'b1;
                    n_ctrl.take_right = (r_from < r_to);
                    n_ctrl.lo         = (r_from < r_to) ? r_from : r_to;
                    n_ctrl.hi         = (r_from < r_to) ? r_to : r_from;
                    n_ctrl.put_en     = 1'b1;
                    n_ctrl.put_pos    = r_to;
                    n_ctrl.put_pri    = w_sel_pri;
                    n_ctrl.put_tag    = w_sel_tag;
                end
            end
            OP_READ: begin
                if (!w_from_ok) begin
                    n_status = STAT_BAD_POS;
                end else begin
                    n_position  = r_from;
                    n_entry_pri = w_sel_pri;
                    n_entry_tag = w_sel_tag;
                end
            end
            default: begin
                n_status = STAT_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_valid <= 1'b0;
            r_ctrl  <= '0;
        end else begin
            r_valid <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_op    <= i_opcode;
                        r_pri   <= i_priority_req;
                        r_tag   <= i_tag;
                        r_from  <= i_from_pos;
                        r_to    <= i_to_pos;
                        r_ge    <= w_ge & w_live;
                        r_match <= w_match & w_live;
                        r_state <= ST_CALC;
                    end
                end
                ST_CALC: begin
                    r_ctrl      <= n_ctrl;
                    r_count     <= n_count;
                    r_status    <= n_status;
                    r_position  <= n_position;
                    r_entry_pri <= n_entry_pri;
                    r_entry_tag <= n_entry_tag;
                    r_valid     <= 1'b1;
                    r_state     <= ST_APPLY;
                end
                ST_APPLY: begin
                    r_ctrl  <= '0;
                    r_state <= ST_IDLE;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_valid          = r_valid;
    assign o_status         = r_status;
    assign o_count          = r_count;
    assign o_position       = r_position;
    assign o_entry_priority = r_entry_pri;
    assign o_entry_tag      = r_entry_tag;

endmodule
`default_nettype wire

// File: test/tb_stable_priority_order_queue_core.sv
// Self-checking testbench for the stable priority order queue core.
`timescale 1ns / 1ps
module tb_stable_priority_order_queue_core;
    import spoq_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [PRI_W-1:0] pri;
        logic [TAG_W-1:0] tag;
        logic [IDX_W-1:0] src_pos;
        logic [IDX_W-1:0] dst_pos;
    } t_command;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [CNT_W-1:0]  count;
        logic [IDX_W-1:0]  position;
        logic [PRI_W-1:0]  pri;
        logic [TAG_W-1:0]  tag;
    } t_outcome;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    logic [OP_W-1:0]   i_opcode = '0;
    logic [PRI_W-1:0]  i_priority_req = '0;
    logic [TAG_W-1:0]  i_tag = '0;
    logic [IDX_W-1:0]  i_from_pos = '0;
    logic [IDX_W-1:0]  i_to_pos = '0;
    logic              o_valid;
    logic [STAT_W-1:0] o_status;
    logic [CNT_W-1:0]  o_count;
    logic [IDX_W-1:0]  o_position;
    logic [PRI_W-1:0]  o_entry_priority;
    logic [TAG_W-1:0]  o_entry_tag;

    // Predicted list contents
    logic [PRI_W-1:0] list_pri [DEPTH];
    logic [TAG_W-1:0] list_tag [DEPTH];
    int               held;

    t_outcome expected_outcomes[$];
    int       mismatches = 0;
    int       cycles = 0;
    int       sender_idle_pct = 0;

    stable_priority_order_queue_core dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_opcode         (i_opcode),
        .i_priority_req   (i_priority_req),
        .i_tag            (i_tag),
        .i_from_pos       (i_from_pos),
        .i_to_pos         (i_to_pos),
        .o_valid          (o_valid),
        .o_status         (o_status),
        .o_count          (o_count),
        .o_position       (o_position),
        .o_entry_priority (o_entry_priority),
        .o_entry_tag      (o_entry_tag)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("tb_stable_priority_order_queue_core NOT OK");
            $finish;
        end
    end

    task automatic apply_command(input t_command c, output t_outcome r);
        int n;
        int p;
        int i;
        logic [PRI_W-1:0] mp;
        logic [TAG_W-1:0] mt;
        r = '0;
        n = held;
        case (c.op)
            OP_INSERT: begin
                if (n >= DEPTH) begin
                    r.status = STAT_FULL;
                end else begin
                    p = 0;
                    for (i = 0; i < n; i++)
                        if (list_pri[i] >= c.pri) p++;
                    for (i = n; i > p; i--) begin
                        list_pri[i] = list_pri[i-1];
                        list_tag[i] = list_tag[i-1];
                    end
                    list_pri[p] = c.pri;
                    list_tag[p] = c.tag;
                    held = n + 1;
                    r.status = STAT_OK;
                    r.position = IDX_W'(p);
                end
            end
            OP_FINISH: begin
                p = 0;
                while (p < n && list_tag[p] != c.tag) p++;
                if (p >= n) begin
                    r.status = STAT_NOT_FOUND;
                end else begin
                    for (i = p; i + 1 < n; i++) begin
                        list_pri[i] = list_pri[i+1];
                        list_tag[i] = list_tag[i+1];
                    end
                    held = n - 1;
                    r.status = STAT_OK;
                    r.position = IDX_W'(p);
                end
            end
            OP_MOVE: begin
                if (c.src_pos >= n || c.dst_pos >= n) begin
                    r.status = STAT_BAD_POS;
                end else begin
                    mp = list_pri[c.src_pos];
                    mt = list_tag[c.src_pos];
                    if (c.src_pos < c.dst_pos) begin
                        for (i = c.src_pos; i < c.dst_pos; i++) begin
                            list_pri[i] = list_pri[i+1];
                            list_tag[i] = list_tag[i+1];
                        end
                    end else begin
                        for (i = c.src_pos; i > c.dst_pos; i--) begin
                            list_pri[i] = list_pri[i-1];
                            list_tag[i] = list_tag[i-1];
                        end
                    end
                    list_pri[c.dst_pos] = mp;
                    list_tag[c.dst_pos] = mt;
                    r.status = STAT_OK;
                    r.position = c.dst_pos;
                end
            end
            default: begin
                if (c.src_pos >= n) begin
                    r.status = STAT_BAD_POS;
                end else begin
                    r.status = STAT_OK;
                    r.position = c.src_pos;
                    r.pri = list_pri[c.src_pos];
                    r.tag = list_tag[c.src_pos];
                end
            end
        endcase
        r.count = CNT_W'(held);
    endtask

    // Leaves start high on return; finish_items lowers it, as does the next call when it waits a gap.
    task automatic issue_command(input t_command c);
        int gap;
        t_outcome r;
        gap = 0;
        if ($urandom_range(99) < sender_idle_pct) gap = $urandom_range(1, 5);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start          <= 1'b1;
        i_opcode       <= c.op;
        i_priority_req <= c.pri;
        i_tag          <= c.tag;
        i_from_pos     <= c.src_pos;
        i_to_pos       <= c.dst_pos;
        do @(posedge i_clk); while (busy !== 1'b0);
        apply_command(c, r);
        expected_outcomes.push_back(r);
    endtask

    task automatic issue(input logic [OP_W-1:0] op, input int pri, input int tag,
                         input int src, input int dst);
        t_command c;
        c.op      = op;
        c.pri     = PRI_W'(pri);
        c.tag     = TAG_W'(tag);
        c.src_pos = IDX_W'(src);
        c.dst_pos = IDX_W'(dst);
        issue_command(c);
    endtask

    task automatic finish_items();
        start <= 1'b0;
        while (expected_outcomes.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin : result_check
        t_outcome want;
        t_outcome got;
        if (i_rst_n === 1'b1 && o_valid === 1'b1) begin
            got = '{o_status, o_count, o_position, o_entry_priority, o_entry_tag};
            if (expected_outcomes.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: st=%0d cnt=%0d pos=%0d pri=%0h tag=%0h",
                             got.status, got.count, got.position, got.pri, got.tag);
            end else begin
                want = expected_outcomes.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch: expected st=%0d cnt=%0d pos=%0d pri=%0h tag=%0h",
                                 want.status, want.count, want.position, want.pri,
                                 want.tag);
                        $display("          got      st=%0d cnt=%0d pos=%0d pri=%0h tag=%0h",
                                 got.status, got.count, got.position, got.pri, got.tag);
                    end
                end
            end
        end
    end

    task automatic test_empty_list();
        issue(OP_READ, 0, 0, 0, 0);
        issue(OP_READ, 0, 0, 15, 0);
        issue(OP_FINISH, 0, 0, 0, 0);
        issue(OP_MOVE, 0, 0, 0, 0);
        issue(OP_MOVE, 255, 16'hFFFF, 15, 15);
        finish_items();
    endtask

    task automatic test_ordering();
        issue(OP_INSERT, 0, 16'h0000, 0, 0);
        issue(OP_INSERT, 255, 16'hFFFF, 0, 0);
        issue(OP_INSERT, 255, 16'h1234, 0, 0);
        issue(OP_INSERT, 128, 16'hFFFF, 0, 0);
        issue(OP_INSERT, 0, 16'h00FF, 15, 15);
        for (int i = 0; i <= 5; i++) issue(OP_READ, 0, 0, i, 0);
        finish_items();
    endtask

    task automatic test_finish_and_move();
        issue(OP_FINISH, 0, 16'hFFFF, 0, 0);
        issue(OP_FINISH, 0, 16'hABCD, 0, 0);
        issue(OP_MOVE, 0, 0, 0, 3);
        issue(OP_MOVE, 0, 0, 3, 0);
        issue(OP_MOVE, 0, 0, 2, 2);
        issue(OP_MOVE, 0, 0, 0, 15);
        issue(OP_MOVE, 0, 0, 15, 0);
        for (int i = 0; i < 4; i++) issue(OP_READ, 0, 0, i, 0);
        finish_items();
    endtask

    task automatic test_full_list();
        while (held < DEPTH) issue(OP_INSERT, $urandom_range(3), $urandom, 0, 0);
        issue(OP_INSERT, 255, 16'hFFFF, 0, 0);
        issue(OP_INSERT, 0, 0, 0, 0);
        issue(OP_READ, 0, 0, 15, 0);
        issue(OP_MOVE, 0, 0, 15, 0);
        issue(OP_MOVE, 0, 0, 0, 15);
        issue(OP_READ, 0, 0, 0, 0);
        while (held > 0) issue(OP_FINISH, 0, list_tag[$urandom_range(held - 1)], 0, 0);
        finish_items();
    endtask

    task automatic random_command(input bit filling, output t_command c);
        int r;
        c = t_command'($bits(t_command)'({$urandom, $urandom}));
        if ($urandom_range(99) < 5) return;
        r = $urandom_range(99);
        if (filling)
            c.op = (r < 55) ? OP_INSERT : (r < 70) ? OP_FINISH : (r < 85) ? OP_MOVE : OP_READ;
        else
            c.op = (r < 15) ? OP_INSERT : (r < 55) ? OP_FINISH : (r < 75) ? OP_MOVE : OP_READ;
        case ($urandom_range(3))
            0: c.pri = PRI_W'($urandom);
            1: c.pri = PRI_W'($urandom_range(3));
            2: c.pri = PRI_W'(252 + $urandom_range(3));
            default: if (held > 0) c.pri = list_pri[$urandom_range(held - 1)];
        endcase
        if (held > 0) begin
            if ((c.op == OP_FINISH && $urandom_range(99) < 80) ||
                (c.op == OP_INSERT && $urandom_range(99) < 25))
                c.tag = list_tag[$urandom_range(held - 1)];
            if ($urandom_range(99) < 85) c.src_pos = IDX_W'($urandom_range(held - 1));
            if ($urandom_range(99) < 85) c.dst_pos = IDX_W'($urandom_range(held - 1));
        end
    endtask

    task automatic test_random(input int idle_pct, input int items);
        t_command c;
        bit filling;
        int run;
        sender_idle_pct = idle_pct;
        filling = 1'b1;
        run = $urandom_range(20, 60);
        for (int k = 0; k < items; k++) begin
            if (--run == 0) begin
                filling = ~filling;
                run = $urandom_range(20, 60);
            end
            random_command(filling, c);
            issue_command(c);
        end
        finish_items();
    endtask

    initial begin
        held = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        sender_idle_pct = 8;
        test_empty_list();
        test_ordering();
        test_finish_and_move();
        test_full_list();
        test_random(8, 500);
        test_random(53, 500);
        test_random(0, 500);

        if (mismatches == 0 && expected_outcomes.size() == 0) begin
            $display("tb_stable_priority_order_queue_core OK");
        end else begin
            $display("tb_stable_priority_order_queue_core NOT OK");
        end
        $finish;
    end

endmodule

// File: files.f
hw/rtl/spoq_pkg.sv
hw/rtl/spoq_cell.sv
hw/rtl/stable_priority_order_queue_core.sv
test/tb_stable_priority_order_queue_core.sv
